// ===== design/fsp_pkg.sv =====
// Shared types, opcodes and helper functions for the five-stage pipeline core.
package fsp_pkg;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_BEQZ  = 6'h04;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;
  localparam logic [5:0] OP_HALT  = 6'h3F;

  localparam logic [10:0] FN_ADD = 11'h020;
  localparam logic [10:0] FN_SUB = 11'h022;
  localparam logic [10:0] FN_SLL = 11'h004;
  localparam logic [10:0] FN_SRL = 11'h006;
  localparam logic [10:0] FN_AND = 11'h024;
  localparam logic [10:0] FN_OR  = 11'h025;

  localparam logic [31:0] NOP_WORD   = 32'h0000_0020;
  localparam logic [31:0] BUBBLE_OFF = 32'd32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic        we;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic [11:0] pc;
    logic [31:0] cycles;
    logic        halted;
    logic        wb_valid;
    logic [4:0]  wb_reg;
    logic [31:0] wb_value;
  } res_t;

  function automatic logic [5:0] op_of(input logic [31:0] w);
    return w[31:26];
  endfunction

  function automatic logic [4:0] ra_of(input logic [31:0] w);
    return w[25:21];
  endfunction

  function automatic logic [4:0] rb_of(input logic [31:0] w);
    return w[20:16];
  endfunction

  function automatic logic [4:0] rd_of(input logic [31:0] w);
    return w[15:11];
  endfunction

  function automatic logic [31:0] sext16(input logic [31:0] w);
    return {{16{w[15]}}, w[15:0]};
  endfunction

  function automatic logic writes_rb(input logic [5:0] op);
    return (op == OP_LW) || (op == OP_ADDI) || (op == OP_BEQZ);
  endfunction

endpackage

// ===== design/fsp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module fsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/fsp_pipe.sv =====
// Pipeline registers and per-cycle stage logic: fetch, decode, forwarding, execute, memory, writeback.
module fsp_pipe
  import fsp_pkg::*;
#(
  parameter int unsigned MEM_AW = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  logic [31:0]       imem_rdata_i,
  input  logic [31:0]       rf_a_i,
  input  logic [31:0]       rf_b_i,
  input  logic [31:0]       dmem_rdata_i,
  output logic [MEM_AW-1:0] fetch_idx_o,
  output logic [4:0]        rf_ra_o,
  output logic [4:0]        rf_rb_o,
  output logic [MEM_AW-1:0] dmem_idx_o,
  output logic              dmem_we_o,
  output logic [31:0]       dmem_wdata_o,
  output rf_wr_t            rf_wr_o,
  output res_t              res_o,
  output logic              stopped_o
);

  logic [11:0] fetch_pc_q, fetch_pc_d;
  logic [31:0] cycles_q;
  logic        stopped_q, stopped_d;
  logic [31:0] si_q [5];
  logic [11:0] npc_q [2];
  logic [31:0] opa_q, opb_q, off_q;
  logic [31:0] alu_q, strd_q;
  logic [31:0] wbv_q [2];

  logic        halt_mm, run;
  logic [31:0] pc_ext, alu_ext;
  logic [31:0] n_if, n_id, na, nb, noff, nalu, nrb, mwd;
  logic [11:0] n_if_pc, n_id_pc;

  assign pc_ext      = {20'd0, fetch_pc_q};
  assign fetch_idx_o = pc_ext[MEM_AW+1:2];
  assign alu_ext     = alu_q;
  assign dmem_idx_o  = alu_ext[MEM_AW+1:2];
  assign rf_ra_o     = ra_of(si_q[0]);
  assign rf_rb_o     = rb_of(si_q[0]);

  // A halt in the memory/writeback register freezes the machine for good.
  assign halt_mm   = (op_of(si_q[3]) == OP_HALT);
  assign run       = tick_i && !stopped_q && !halt_mm;
  assign stopped_d = stopped_q | (tick_i && halt_mm);
  assign stopped_o = stopped_q;

  always_comb begin
    logic [11:0] newpc, idpc;
    logic [31:0] a, b, off, brt, rt_word;
    logic [5:0]  iop, eop, mop, wop, dop;
    logic [4:0]  ir1, ir2, rt;
    logic        stall, neg, fwd_taken, back_missed;

    // Fetch, with backward branches predicted taken.
    newpc   = fetch_pc_q + 12'd4;
    n_if    = imem_rdata_i;
    n_if_pc = newpc;
    brt     = sext16(n_if);
    if (op_of(n_if) == OP_BEQZ && n_if[15]) begin
      newpc = newpc + brt[11:0];
    end

    // Decode and load-use interlock.
    na   = rf_a_i;
    nb   = rf_b_i;
    dop  = op_of(si_q[0]);
    noff = (dop == OP_LW || dop == OP_SW || dop == OP_BEQZ || dop == OP_ADDI) ?
           sext16(si_q[0]) : {16'd0, si_q[0][15:0]};
    stall   = 1'b0;
    rt_word = si_q[1];
    rt      = rb_of(rt_word);
    if (op_of(si_q[1]) == OP_LW) begin
      if (dop == OP_RTYPE) begin
        stall = (rt == ra_of(si_q[0])) || (rt == rb_of(si_q[0]));
      end else if (dop == OP_LW || dop == OP_BEQZ || dop == OP_ADDI) begin
        stall = (rt == ra_of(si_q[0]));
      end
    end
    if (stall) begin
      n_if    = si_q[0];
      n_if_pc = npc_q[0];
      na      = '0;
      nb      = '0;
      n_id_pc = '0;
      noff    = BUBBLE_OFF;
      n_id    = NOP_WORD;
      newpc   = newpc - 12'd4;
    end else begin
      n_id_pc = npc_q[0];
      n_id    = si_q[0];
    end

    // Execute operands: forwarding applied oldest source first.
    a    = opa_q;
    b    = opb_q;
    off  = off_q;
    idpc = npc_q[1];
    iop  = op_of(si_q[1]);
    ir1  = ra_of(si_q[1]);
    ir2  = rb_of(si_q[1]);

    wop = op_of(si_q[4]);
    if (wop == OP_RTYPE) begin
      if (ir1 != 5'd0 && ir1 == rd_of(si_q[4])) a = wbv_q[1];
      if (ir2 != 5'd0 && ir2 == rd_of(si_q[4])) b = wbv_q[1];
    end else if (writes_rb(wop)) begin
      if (ir1 != 5'd0 && ir1 == rb_of(si_q[4])) a = wbv_q[1];
      if (ir2 != 5'd0 && iop != wop && ir2 == rb_of(si_q[4])) b = wbv_q[1];
    end else if (wop == OP_SW) begin
      if (ir2 != 5'd0 && ir2 == rb_of(si_q[4])) b = wbv_q[1];
    end
    mop = op_of(si_q[3]);
    if (mop == OP_RTYPE) begin
      if (ir1 != 5'd0 && ir1 == rd_of(si_q[3])) a = wbv_q[0];
      if (ir2 != 5'd0 && ir2 == rd_of(si_q[3]) && iop != OP_ADDI) b = wbv_q[0];
    end else if (writes_rb(mop)) begin
      if (ir1 != 5'd0 && ir1 == rb_of(si_q[3])) a = wbv_q[0];
      if (ir2 != 5'd0 && iop != mop && ir2 == rb_of(si_q[3])) b = wbv_q[0];
    end
    eop = op_of(si_q[2]);
    if (eop == OP_RTYPE) begin
      if (ir1 != 5'd0 && ir1 == rd_of(si_q[2])) a = alu_q;
      if (ir2 != 5'd0 && ir2 == rd_of(si_q[2]) && iop != OP_LW) b = alu_q;
    end else if (writes_rb(eop)) begin
      if (ir1 != 5'd0 && ir1 == rb_of(si_q[2])) a = alu_q;
      if (ir2 != 5'd0 && iop != eop && ir2 == rb_of(si_q[2]) && iop != OP_ADDI) begin
        b = alu_q;
      end
    end

    // Execute.
    nalu = alu_q;
    nrb  = strd_q;
    neg         = off[31];
    fwd_taken   = (a == 32'd0) && (off != 32'd0) && !neg;
    back_missed = (a != 32'd0) && neg;
    if (iop == OP_RTYPE) begin
      if (rd_of(si_q[1]) == 5'd0) begin
        nalu = '0;
      end else begin
        case (si_q[1][10:0])
          FN_ADD:  nalu = a + b;
          FN_SUB:  nalu = a - b;
          FN_SLL:  nalu = a << b[4:0];
          FN_SRL:  nalu = a >> b[4:0];
          FN_AND:  nalu = a & b;
          FN_OR:   nalu = a | b;
          default: nalu = alu_q;
        endcase
      end
      nrb = b;
    end else if (iop == OP_LW || iop == OP_ADDI || iop == OP_SW) begin
      if (iop == OP_ADDI && ir2 == 5'd0) begin
        nalu = '0;
        nrb  = '0;
      end else begin
        nalu = a + off;
        nrb  = b;
      end
    end else if (iop == OP_BEQZ) begin
      nalu = {20'd0, idpc} + off;
      nrb  = b;
      if (fwd_taken || back_missed) begin
        newpc   = fwd_taken ? nalu[11:0] : idpc;
        n_if    = NOP_WORD;
        n_id    = NOP_WORD;
        n_id_pc = '0;
        n_if_pc = '0;
        na      = '0;
        nb      = '0;
        noff    = BUBBLE_OFF;
      end
    end else if (iop == OP_HALT) begin
      nalu = '0;
      nrb  = '0;
    end

    // Memory access.
    dmem_we_o    = 1'b0;
    dmem_wdata_o = strd_q;
    if (eop == OP_LW) begin
      mwd = (rb_of(si_q[2]) == 5'd0) ? 32'd0 : dmem_rdata_i;
    end else if (eop == OP_SW) begin
      dmem_we_o = run;
      mwd       = strd_q;
    end else if ((eop == OP_ADDI && rb_of(si_q[2]) == 5'd0) ||
                 (eop == OP_RTYPE && rd_of(si_q[2]) == 5'd0)) begin
      mwd = '0;
    end else begin
      mwd = alu_q;
    end

    // Writeback.
    rf_wr_o = '0;
    if (mop == OP_LW || mop == OP_ADDI) begin
      rf_wr_o.we   = run;
      rf_wr_o.idx  = rb_of(si_q[3]);
      rf_wr_o.data = wbv_q[0];
    end else if (mop == OP_RTYPE) begin
      rf_wr_o.we   = run;
      rf_wr_o.idx  = rd_of(si_q[3]);
      rf_wr_o.data = wbv_q[0];
    end

    fetch_pc_d = newpc;
  end

  always_comb begin
    res_o          = '0;
    res_o.pc       = run ? fetch_pc_d : fetch_pc_q;
    res_o.cycles   = run ? cycles_q + 32'd1 : cycles_q;
    res_o.halted   = stopped_d;
    res_o.wb_valid = rf_wr_o.we;
    if (rf_wr_o.we) begin
      res_o.wb_reg   = rf_wr_o.idx;
      res_o.wb_value = rf_wr_o.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_pc_q <= '0;
      cycles_q   <= '0;
      stopped_q  <= 1'b0;
      for (int i = 0; i < 5; i++) si_q[i] <= NOP_WORD;
      npc_q[0]   <= '0;
      npc_q[1]   <= '0;
      opa_q      <= '0;
      opb_q      <= '0;
      off_q      <= '0;
      alu_q      <= '0;
      strd_q     <= '0;
      wbv_q[0]   <= '0;
      wbv_q[1]   <= '0;
    end else begin
      stopped_q <= stopped_d;
      if (run) begin
        fetch_pc_q <= fetch_pc_d;
        cycles_q   <= cycles_q + 32'd1;
        si_q[4]    <= si_q[3];
        si_q[3]    <= si_q[2];
        si_q[2]    <= si_q[1];
        si_q[1]    <= n_id;
        si_q[0]    <= n_if;
        npc_q[0]   <= n_if_pc;
        npc_q[1]   <= n_id_pc;
        opa_q      <= na;
        opb_q      <= nb;
        off_q      <= noff;
        alu_q      <= nalu;
        strd_q     <= nrb;
        wbv_q[1]   <= wbv_q[0];
        wbv_q[0]   <= mwd;
      end
    end
  end

endmodule

// ===== design/five_stage_pipeline_core.sv =====
// A load request's result is written to a result slot as the request is accepted; a step request's
// result is written from the execute state. One load request per cycle while a slot is free;
// no request is taken while a step request is in its execute state (memory read, then compute and
// write back through the same synchronous memories). Two result registers let new requests enter
// while results wait at the output. After reset a clearing pass zeroes the memories and the
// register file; no request is accepted until it ends. MEM_WORDS must be a power of two.
module five_stage_pipeline_core
  import fsp_pkg::*;
#(
  parameter int unsigned MEM_WORDS = 1024,
  parameter int unsigned REG_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [9:0]  word_address_i,
  input  logic [31:0] load_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] program_counter_o,
  output logic [31:0] cycle_count_o,
  output logic        halted_o,
  output logic        writeback_valid_o,
  output logic [4:0]  writeback_register_o,
  output logic [31:0] writeback_value_o
);

  localparam int unsigned AW    = $clog2(MEM_WORDS);
  localparam int unsigned RW    = $clog2(REG_COUNT);
  localparam int unsigned CLR_N = (MEM_WORDS > REG_COUNT) ? MEM_WORDS : REG_COUNT;
  localparam int unsigned CW    = $clog2(CLR_N);

  state_e      state_q, state_d;
  logic [CW-1:0] clr_q;
  logic        clearing, acc, load_acc, push, pop;
  logic [1:0]  cnt_q, widx;
  res_t        slot_q [2];
  res_t        res;
  rf_wr_t      rf_wr;
  logic [31:0] la_ext;
  logic [AW-1:0] load_idx, fetch_idx, dmem_idx;
  logic [4:0]  rf_ra, rf_rb;
  logic        dmem_we, stopped;
  logic [31:0] dmem_wdata, imem_rdata, dmem_rdata, rf_a, rf_b;

  logic          imem_we, dm_we, rf_we;
  logic [AW-1:0] imem_waddr, dm_waddr;
  logic [31:0]   imem_wdata, dm_wdata, rf_wdata;
  logic [RW-1:0] rf_waddr;

  assign clearing = (state_q == ST_CLEAR);
  assign in_ready_o = (state_q == ST_IDLE) && (cnt_q != 2'd2);
  assign acc      = in_valid_i && in_ready_o;
  assign load_acc = acc && (command_i == CMD_LOAD);
  assign push     = load_acc || (state_q == ST_EXEC);
  assign pop      = out_valid_o && out_ready_i;

  assign la_ext   = {22'd0, word_address_i};
  assign load_idx = la_ext[AW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == CW'(CLR_N - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (acc && command_i == CMD_STEP) state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (clearing) clr_q <= clr_q + CW'(1);
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign widx = cnt_q - {1'b0, pop};

  // A new result lands in the slot that is free after this cycle's pop.
  always_ff @(posedge clk_i) begin
    if (push && (widx[0] == 1'b0)) begin
      slot_q[0] <= res;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
    end
    if (push && widx[0]) slot_q[1] <= res;
  end

  assign out_valid_o          = (cnt_q != 2'd0);
  assign program_counter_o    = slot_q[0].pc;
  assign cycle_count_o        = slot_q[0].cycles;
  assign halted_o             = slot_q[0].halted;
  assign writeback_valid_o    = slot_q[0].wb_valid;
  assign writeback_register_o = slot_q[0].wb_reg;
  assign writeback_value_o    = slot_q[0].wb_value;

  // Memory write ports: clearing pass, then load requests, then the machine itself.
  assign imem_we    = clearing || load_acc;
  assign imem_waddr = clearing ? clr_q[AW-1:0] : load_idx;
  assign imem_wdata = clearing ? 32'd0 : load_word_i;

  assign dm_we    = clearing || load_acc || dmem_we;
  assign dm_waddr = clearing ? clr_q[AW-1:0] : (load_acc ? load_idx : dmem_idx);
  assign dm_wdata = clearing ? 32'd0 : (load_acc ? load_word_i : dmem_wdata);

  assign rf_we    = clearing || rf_wr.we;
  assign rf_waddr = clearing ? clr_q[RW-1:0] : rf_wr.idx[RW-1:0];
  assign rf_wdata = clearing ? 32'd0 : rf_wr.data;

  fsp_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_imem (
    .clk_i, .we_i(imem_we), .waddr_i(imem_waddr), .wdata_i(imem_wdata),
    .raddr_i(fetch_idx), .rdata_o(imem_rdata)
  );

  fsp_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
    .clk_i, .we_i(dm_we), .waddr_i(dm_waddr), .wdata_i(dm_wdata),
    .raddr_i(dmem_idx), .rdata_o(dmem_rdata)
  );

  // The register file is kept twice so that both source operands are read in the same cycle.
  fsp_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rf_ra[RW-1:0]), .rdata_o(rf_a)
  );

  fsp_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rf_rb[RW-1:0]), .rdata_o(rf_b)
  );

  fsp_pipe #(.MEM_AW(AW)) u_pipe (
    .clk_i,
    .rst_ni,
    .tick_i       (state_q == ST_EXEC),
    .imem_rdata_i (imem_rdata),
    .rf_a_i       (rf_a),
    .rf_b_i       (rf_b),
    .dmem_rdata_i (dmem_rdata),
    .fetch_idx_o  (fetch_idx),
    .rf_ra_o      (rf_ra),
    .rf_rb_o      (rf_rb),
    .dmem_idx_o   (dmem_idx),
    .dmem_we_o    (dmem_we),
    .dmem_wdata_o (dmem_wdata),
    .rf_wr_o      (rf_wr),
    .res_o        (res),
    .stopped_o    (stopped)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (cnt_q != 2'd2))
    else $error("result buffer overflow");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !push)
    else $error("result produced during clearing pass");

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped |=> stopped)
    else $error("halt state was left");

  a_no_write_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped |-> !rf_wr.we && !dmem_we)
    else $error("machine wrote state after halt");

endmodule

// ===== tb/five_stage_pipeline_core_tb.sv =====
// Self-checking testbench for the five-stage pipeline core, with its own cycle model.
`timescale 1ns / 100ps

module five_stage_pipeline_core_tb;
  import fsp_pkg::*;

  localparam int MEM_DEPTH = 1024;

  typedef struct {
    logic        cmd;
    logic [9:0]  addr;
    logic [31:0] word;
    bit          typed;
    res_t        res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = CMD_LOAD;
  logic [9:0]  word_address_i = '0;
  logic [31:0] load_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [11:0] program_counter_o;
  logic [31:0] cycle_count_o;
  logic        halted_o;
  logic        writeback_valid_o;
  logic [4:0]  writeback_register_o;
  logic [31:0] writeback_value_o;

  five_stage_pipeline_core dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Model of the core's architectural and pipeline state.
  logic [31:0] imem [MEM_DEPTH];
  logic [31:0] dmem [MEM_DEPTH];
  logic [31:0] regs [32];
  logic [11:0] fpc;
  logic [31:0] cyc;
  bit          stop;
  logic [31:0] stg [5];
  logic [11:0] npc [2];
  logic [31:0] opnd [3];
  logic [31:0] exr [2];
  logic [31:0] wbv [2];

  res_t pending_q [$];
  int   err_cnt = 0;
  int   rx_cnt = 0;
  int   items = 0;
  bit   tx_burst = 0;
  bit   rx_burst = 0;

  function automatic logic [31:0] sx16(input logic [31:0] w);
    return {{16{w[15]}}, w[15:0]};
  endfunction

  function automatic bit writes_b(input logic [5:0] op);
    return op == OP_LW || op == OP_ADDI || op == OP_BEQZ;
  endfunction

  task automatic core_reset();
    for (int i = 0; i < MEM_DEPTH; i++) begin
      imem[i] = '0;
      dmem[i] = '0;
    end
    for (int i = 0; i < 32; i++) regs[i] = '0;
    for (int i = 0; i < 5; i++) stg[i] = NOP_WORD;
    fpc = '0; cyc = '0; stop = 0;
    npc[0] = '0; npc[1] = '0;
    opnd[0] = '0; opnd[1] = '0; opnd[2] = '0;
    exr[0] = '0; exr[1] = '0; wbv[0] = '0; wbv[1] = '0;
  endtask

  // Advances the model machine through all five stages once.
  task automatic core_cycle(output bit wv, output logic [4:0] wr, output logic [31:0] wval);
    logic [31:0] s_if, s_id, s_ex, s_mm, s_wb, n_if, n_id, na, nb, noff;
    logic [31:0] a, b, off, nalu, nrb, mwd, alu, brt;
    logic [11:0] newpc, n_if_pc, n_id_pc, idpc;
    logic [5:0]  iop, wop, mop, eop;
    logic [4:0]  ir1, ir2, rt;
    logic [9:0]  didx;
    bit          stall, neg, fwd_taken, back_missed;
    wv = 0; wr = '0; wval = '0;
    s_if = stg[0]; s_id = stg[1]; s_ex = stg[2]; s_mm = stg[3]; s_wb = stg[4];
    stall = 0;
    if (s_mm[31:26] == OP_HALT) begin
      stop = 1;
      return;
    end

    newpc = fpc + 12'd4;
    n_if = imem[fpc[11:2]];
    n_if_pc = newpc;
    brt = sx16(n_if);
    if (n_if[31:26] == OP_BEQZ && n_if[15]) newpc = newpc + brt[11:0];

    na = regs[s_if[25:21]];
    nb = regs[s_if[20:16]];
    iop = s_if[31:26];
    noff = (iop == OP_LW || iop == OP_SW || iop == OP_BEQZ || iop == OP_ADDI) ?
           sx16(s_if) : {16'h0, s_if[15:0]};
    if (s_id[31:26] == OP_LW) begin
      rt = s_id[20:16];
      if (iop == OP_RTYPE) stall = (rt == s_if[25:21]) || (rt == s_if[20:16]);
      else if (iop == OP_LW || iop == OP_BEQZ || iop == OP_ADDI) stall = (rt == s_if[25:21]);
    end
    if (stall) begin
      n_if = s_if; n_if_pc = npc[0];
      na = '0; nb = '0; n_id_pc = '0; noff = BUBBLE_OFF; n_id = NOP_WORD;
      newpc = newpc - 12'd4;
    end else begin
      n_id_pc = npc[0]; n_id = s_if;
    end

    // Forwarding: the oldest source is applied first so that younger ones win.
    a = opnd[0]; b = opnd[1]; off = opnd[2]; idpc = npc[1];
    iop = s_id[31:26]; ir1 = s_id[25:21]; ir2 = s_id[20:16];
    wop = s_wb[31:26];
    if (wop == OP_RTYPE) begin
      if (ir1 != 0 && ir1 == s_wb[15:11]) a = wbv[1];
      if (ir2 != 0 && ir2 == s_wb[15:11]) b = wbv[1];
    end else if (writes_b(wop)) begin
      if (ir1 != 0 && ir1 == s_wb[20:16]) a = wbv[1];
      if (ir2 != 0 && iop != wop && ir2 == s_wb[20:16]) b = wbv[1];
    end else if (wop == OP_SW) begin
      if (ir2 != 0 && ir2 == s_wb[20:16]) b = wbv[1];
    end
    mop = s_mm[31:26];
    if (mop == OP_RTYPE) begin
      if (ir1 != 0 && ir1 == s_mm[15:11]) a = wbv[0];
      if (ir2 != 0 && ir2 == s_mm[15:11] && iop != OP_ADDI) b = wbv[0];
    end else if (writes_b(mop)) begin
      if (ir1 != 0 && ir1 == s_mm[20:16]) a = wbv[0];
      if (ir2 != 0 && iop != mop && ir2 == s_mm[20:16]) b = wbv[0];
    end
    eop = s_ex[31:26];
    if (eop == OP_RTYPE) begin
      if (ir1 != 0 && ir1 == s_ex[15:11]) a = exr[0];
      if (ir2 != 0 && ir2 == s_ex[15:11] && iop != OP_LW) b = exr[0];
    end else if (writes_b(eop)) begin
      if (ir1 != 0 && ir1 == s_ex[20:16]) a = exr[0];
      if (ir2 != 0 && iop != eop && ir2 == s_ex[20:16] && iop != OP_ADDI) b = exr[0];
    end

    nalu = exr[0]; nrb = exr[1];
    if (iop == OP_RTYPE) begin
      if (s_id[15:11] == 0) nalu = '0;
      else case (s_id[10:0])
        FN_ADD: nalu = a + b;
        FN_SUB: nalu = a - b;
        FN_SLL: nalu = a << b[4:0];
        FN_SRL: nalu = a >> b[4:0];
        FN_AND: nalu = a & b;
        FN_OR:  nalu = a | b;
        default: ;
      endcase
      nrb = b;
    end else if (iop == OP_LW || iop == OP_ADDI || iop == OP_SW) begin
      if (iop == OP_ADDI && ir2 == 0) begin
        nalu = '0; nrb = '0;
      end else begin
        nalu = a + off; nrb = b;
      end
    end else if (iop == OP_BEQZ) begin
      neg = off[31];
      fwd_taken = (a == 0) && off != 0 && !neg;
      back_missed = (a != 0) && neg;
      nalu = {20'h0, idpc} + off; nrb = b;
      if (fwd_taken || back_missed) begin
        newpc = fwd_taken ? off[11:0] + idpc : idpc;
        n_if = NOP_WORD; n_id = NOP_WORD;
        n_id_pc = '0; n_if_pc = '0; na = '0; nb = '0; noff = BUBBLE_OFF;
      end
    end else if (iop == OP_HALT) begin
      nalu = '0; nrb = '0;
    end

    alu = exr[0];
    didx = alu[11:2];
    if (eop == OP_LW) begin
      mwd = (s_ex[20:16] == 0) ? '0 : dmem[didx];
    end else if (eop == OP_SW) begin
      dmem[didx] = exr[1];
      mwd = exr[1];
    end else if ((eop == OP_ADDI && s_ex[20:16] == 0) || (eop == OP_RTYPE && s_ex[15:11] == 0)) begin
      mwd = '0;
    end else begin
      mwd = alu;
    end

    if (mop == OP_LW || mop == OP_ADDI) begin
      wv = 1; wr = s_mm[20:16]; wval = wbv[0]; regs[wr] = wval;
    end else if (mop == OP_RTYPE) begin
      wv = 1; wr = s_mm[15:11]; wval = wbv[0]; regs[wr] = wval;
    end

    wbv[1] = wbv[0]; wbv[0] = mwd;
    exr[0] = nalu; exr[1] = nrb;
    opnd[0] = na; opnd[1] = nb; opnd[2] = noff;
    npc[0] = n_if_pc; npc[1] = n_id_pc;
    stg[4] = s_mm; stg[3] = s_ex; stg[2] = s_id; stg[1] = n_id; stg[0] = n_if;
    fpc = newpc;
    cyc = cyc + 1;
  endtask

  task automatic core_request(input logic cmd, input logic [9:0] addr, input logic [31:0] word,
                              output res_t r);
    bit          wv;
    logic [4:0]  wr;
    logic [31:0] wval;
    wv = 0; wr = '0; wval = '0;
    if (cmd == CMD_LOAD) begin
      imem[addr] = word;
      dmem[addr] = word;
    end else if (!stop) begin
      core_cycle(wv, wr, wval);
    end
    r.pc = fpc; r.cycles = cyc; r.halted = stop;
    r.wb_valid = wv; r.wb_reg = wr; r.wb_value = wval;
  endtask

  // Called just after a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input logic cmd, input logic [9:0] addr, input logic [31:0] word,
                              input bit typed, input res_t typed_res);
    int   gap;
    res_t r;
    if ($urandom_range(0, 59) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i <= cmd;
    word_address_i <= addr;
    load_word_i <= word;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    core_request(cmd, addr, word, r);
    pending_q.push_back(typed ? typed_res : r);
    items++;
  endtask

  function automatic logic [31:0] rand_insn();
    int          k;
    logic [4:0]  r1, r2, r3;
    logic [10:0] fn;
    logic [15:0] imm;
    logic [31:0] w;
    k = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) begin
      r1 = 5'($urandom_range(0, 31));
      r2 = 5'($urandom_range(0, 31));
      r3 = 5'($urandom_range(0, 31));
    end else begin
      r1 = 5'($urandom_range(0, 7));
      r2 = 5'($urandom_range(0, 7));
      r3 = 5'($urandom_range(0, 7));
    end
    imm = 16'($urandom);
    if (k < 40) begin
      case ($urandom_range(0, 6))
        0: fn = FN_ADD;
        1: fn = FN_SUB;
        2: fn = FN_SLL;
        3: fn = FN_SRL;
        4: fn = FN_AND;
        5: fn = FN_OR;
        default: fn = 11'($urandom);
      endcase
      w = {OP_RTYPE, r1, r2, r3, fn};
    end else if (k < 55) w = {OP_ADDI, r1, r2, imm};
    else if (k < 68) w = {OP_LW, r1, r2, imm};
    else if (k < 80) w = {OP_SW, r1, r2, imm};
    else if (k < 92) begin
      case ($urandom_range(0, 2))
        0: imm = -16'($urandom_range(1, 6) * 4);
        1: imm = 16'($urandom_range(1, 6) * 4);
        default: imm = '0;
      endcase
      w = {OP_BEQZ, r1, r2, imm};
    end else if (k < 96) w = NOP_WORD;
    else begin
      w = $urandom;
      if (w[31:26] == OP_HALT) w[31:26] = OP_SW;
    end
    return w;
  endfunction

  // Receiver: random hold-offs, plus one long stall that backs the core up.
  initial begin
    int d;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_burst = ~rx_burst;
      d = rx_burst ? 0 : $urandom_range(0, 14);
      if (rx_cnt == 200) d = 300;
      if (d > 0) begin
        out_ready_i <= 1'b0;
        repeat (d) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      rx_cnt++;
    end
  end

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result pc=%h cycles=%h", $time, program_counter_o,
                 cycle_count_o);
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (program_counter_o !== e.pc || cycle_count_o !== e.cycles ||
            halted_o !== e.halted || writeback_valid_o !== e.wb_valid ||
            writeback_register_o !== e.wb_reg || writeback_value_o !== e.wb_value) begin
          $display("%0t: expected pc=%h cyc=%h halt=%b wb=%b r%0d=%h", $time, e.pc,
                   e.cycles, e.halted, e.wb_valid, e.wb_reg, e.wb_value);
          $display("%0t: actual   pc=%h cyc=%h halt=%b wb=%b r%0d=%h", $time,
                   program_counter_o, cycle_count_o, halted_o, writeback_valid_o,
                   writeback_register_o, writeback_value_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    stim_row_t   rows [25];
    res_t        zero_res, dummy;
    logic [9:0]  pcw;
    int          n;
    bit          drained;
    core_reset();
    drained = 0;
    zero_res = '{default: '0};
    dummy = zero_res;
    foreach (rows[i]) rows[i] = '{CMD_STEP, '0, '0, 0, zero_res};
    rows[0]  = '{CMD_LOAD, 10'd0, {OP_ADDI, 5'd0, 5'd1, 16'h7FFF}, 1, zero_res};
    rows[1]  = '{CMD_LOAD, 10'd1, {OP_ADDI, 5'd0, 5'd2, 16'h8000}, 0, zero_res};
    rows[2]  = '{CMD_LOAD, 10'd2, {OP_RTYPE, 5'd1, 5'd2, 5'd3, FN_ADD}, 0, zero_res};
    rows[3]  = '{CMD_LOAD, 10'd3, {OP_RTYPE, 5'd1, 5'd2, 5'd4, FN_SUB}, 0, zero_res};
    rows[4]  = '{CMD_LOAD, 10'd4, {OP_RTYPE, 5'd1, 5'd2, 5'd5, FN_SLL}, 0, zero_res};
    rows[5]  = '{CMD_LOAD, 10'd5, {OP_RTYPE, 5'd2, 5'd1, 5'd6, FN_SRL}, 0, zero_res};
    rows[6]  = '{CMD_LOAD, 10'd6, {OP_RTYPE, 5'd1, 5'd2, 5'd7, FN_AND}, 0, zero_res};
    rows[7]  = '{CMD_LOAD, 10'd7, {OP_RTYPE, 5'd1, 5'd2, 5'd8, FN_OR}, 0, zero_res};
    rows[8]  = '{CMD_LOAD, 10'd8, {OP_SW, 5'd0, 5'd3, 16'h0040}, 0, zero_res};
    rows[9]  = '{CMD_LOAD, 10'd9, {OP_LW, 5'd0, 5'd9, 16'h0040}, 0, zero_res};
    // The add right behind the load is held in decode by the load-use interlock until its operand is ready.
    rows[10] = '{CMD_LOAD, 10'd10, {OP_RTYPE, 5'd9, 5'd9, 5'd10, FN_ADD}, 0, zero_res};
    rows[11] = '{CMD_LOAD, 10'd11, {OP_BEQZ, 5'd0, 5'd0, 16'h0008}, 0, zero_res};
    rows[12] = '{CMD_LOAD, 10'd14, {OP_BEQZ, 5'd1, 5'd0, 16'hFFFC}, 0, zero_res};
    rows[13] = '{CMD_LOAD, 10'd1023, 32'hF7FF_FFFF, 1, zero_res};
    rows[14].typed = 1;
    rows[14].res = '{pc: 12'd4, cycles: 32'd1, halted: 1'b0, wb_valid: 1'b1,
                     wb_reg: 5'd0, wb_value: 32'd0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_request(rows[i].cmd, rows[i].addr, rows[i].word, rows[i].typed,
                                   rows[i].res);

    // Random programs written from the fetch address on, then run.
    while (items < 900) begin
      if (!drained && items > 500) begin
        drained = 1;
        in_valid_i <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      pcw = fpc[11:2];
      n = $urandom_range(3, 12);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_request(CMD_LOAD, 10'($urandom), $urandom, 0, dummy);
        else
          send_request(CMD_LOAD, pcw + 10'(k), rand_insn(), 0, dummy);
      end
      n = $urandom_range(4, 24);
      for (int k = 0; k < n; k++) send_request(CMD_STEP, '0, '0, 0, dummy);
    end

    // Close with a halt and make sure later steps leave the core stopped.
    pcw = fpc[11:2];
    for (int k = 0; k < 24; k++)
      send_request(CMD_LOAD, pcw + 10'(k), {OP_HALT, 26'h0}, 0, dummy);
    for (int k = 0; k < 40 && !stop; k++) send_request(CMD_STEP, '0, '0, 0, dummy);
    send_request(CMD_LOAD, 10'h155, 32'hAAAA_5555, 0, dummy);
    repeat (3) send_request(CMD_STEP, '0, '0, 0, dummy);
    in_valid_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fsp_pkg.sv
design/fsp_ram.sv
design/fsp_pipe.sv
design/five_stage_pipeline_core.sv
tb/five_stage_pipeline_core_tb.sv
